// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/chmap_pkg.sv =====
`timescale 1ns / 1ps

package chmap_pkg;

  // fixed field widths
  localparam int KEY_W   = 31;
  localparam int VALUE_W = 32;
  localparam int BCNT_W  = 9;

  // storage defaults
  localparam int MAX_BUCKETS_DEF = 256;
  localparam int NODE_POOL_DEF   = 1024;

  // remainder unit: dividend bits handled per cycle
  localparam int MOD_BITS_PER_CYC = 4;
  localparam int MOD_DIVIDEND_W   = 32;
  localparam int MOD_CYCLES       = MOD_DIVIDEND_W / MOD_BITS_PER_CYC;

  typedef enum logic [0:0] {
    OP_ADD  = 1'b0,
    OP_FIND = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    ST_OK   = 1'b0,
    ST_FULL = 1'b1
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] found_value;
    status_t            status;
  } out_beat_t;

  // remainder unit status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

// ===== rtl/chmap_ram.sv =====
`timescale 1ns / 1ps

module chmap_ram #(
  parameter int DEPTH = 256,
  parameter int HI_W  = 8,
  parameter int LO_W  = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we_hi,
  input  logic                 we_lo,
  input  logic [AW-1:0]        addr,
  input  logic [HI_W+LO_W-1:0] wdata,
  output logic [HI_W+LO_W-1:0] rdata
);

  localparam int W = HI_W + LO_W;

  logic [W-1:0] mem [DEPTH];

  // single port, two write lanes, registered read
  always_ff @(posedge clk) begin
    if (we_hi) begin
      mem[addr][W-1:LO_W] <= wdata[W-1:LO_W];
    end
    if (we_lo) begin
      mem[addr][LO_W-1:0] <= wdata[LO_W-1:0];
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/chmap_mod.sv =====
`timescale 1ns / 1ps

module chmap_mod (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [chmap_pkg::KEY_W-1:0]    key,
  input  logic [chmap_pkg::BCNT_W-1:0]   divisor,
  output chmap_pkg::mod_stat_t           stat,
  output logic [chmap_pkg::BCNT_W-1:0]   rem
);

  import chmap_pkg::*;

  localparam int CW = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

  logic [MOD_DIVIDEND_W-1:0] q_r;
  logic [BCNT_W-1:0]         rem_r;
  logic [BCNT_W-1:0]         div_r;
  logic [CW-1:0]             cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [BCNT_W-1:0]         rem_nxt;

  // restoring remainder steps, a few dividend bits per cycle
  always_comb begin
    logic [BCNT_W:0] r;
    r = '0;
    rem_nxt = rem_r;
    for (int i = 0; i < MOD_BITS_PER_CYC; i++) begin
      r = {rem_nxt, q_r[MOD_DIVIDEND_W-1-i]};
      if (r >= {1'b0, div_r}) begin
        r = r - {1'b0, div_r};
      end
      rem_nxt = r[BCNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses the cycle after the last step
      done_r <= busy_r && !start && (cnt_r == CW'(MOD_CYCLES - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= MOD_DIVIDEND_W'(key);
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= q_r << MOD_BITS_PER_CYC;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MOD_CYCLES - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

// ===== rtl/chained_hash_map_insert_lookup_unit.sv =====
`timescale 1ns / 1ps
// add: the 8-step remainder unit, a bucket read, a check that writes bucket and new node,
// then a link write to the old tail when appended; refused add (pool full): the remainder
// unit only; find: remainder unit, bucket read and check, then a node read and key compare
// per node; one item at a time, the next beat can enter in the cycle the result appears
// reset: synchronous, active low; a clearing pass then empties all MAX_BUCKETS entries of
// the bucket table, with the input stalled; the bucket count cfg_r resets to 256
module chained_hash_map_insert_lookup_unit #(
  parameter int MAX_BUCKETS    = chmap_pkg::MAX_BUCKETS_DEF,
  parameter int NODE_POOL_SIZE = chmap_pkg::NODE_POOL_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  chmap_pkg::in_beat_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output chmap_pkg::out_beat_t          out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [chmap_pkg::BCNT_W-1:0]  cfg_data
);

  import chmap_pkg::*;

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = (NODE_POOL_SIZE > 1) ? $clog2(NODE_POOL_SIZE) : 1;
  localparam int CW = $clog2(NODE_POOL_SIZE + 1);
  localparam int BKT_HI_W = 1 + NW;
  localparam int BKT_LO_W = NW;
  localparam int NODE_HI_W = KEY_W + VALUE_W;
  localparam int NODE_LO_W = 1 + NW;
  localparam logic [BCNT_W:0] BktCap =
    (MAX_BUCKETS > ((1 << BCNT_W) - 1)) ? (BCNT_W + 1)'((1 << BCNT_W) - 1)
                                        : (BCNT_W + 1)'(MAX_BUCKETS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_BRD, S_BCHK, S_LINK, S_NRD, S_NCHK, S_DONE
  } state_t;

  state_t             state_r;
  logic [BCNT_W-1:0]  cfg_r;
  op_t                op_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] val_r;
  logic [BW-1:0]      bkt_r;
  logic [BW-1:0]      clr_r;
  logic [CW-1:0]      alloc_r;
  logic [NW-1:0]      nidx_r;
  logic [NW-1:0]      tail_r;
  logic [NW-1:0]      cur_r;
  out_beat_t          res_r;
  logic               out_valid_r;
  out_beat_t          out_data_r;

  logic [BCNT_W-1:0]  eff_bkt;
  logic               in_beat;
  logic               pool_full;
  logic [NW-1:0]      new_idx;
  logic               slot_free;

  mod_stat_t          mod_st;
  logic [BCNT_W-1:0]  mod_rem;

  logic                         bkt_we;
  logic [BW-1:0]                bkt_addr;
  logic [BKT_HI_W+BKT_LO_W-1:0] bkt_wdata;
  logic [BKT_HI_W+BKT_LO_W-1:0] bkt_rdata;
  logic                         b_used;
  logic [NW-1:0]                b_head;
  logic [NW-1:0]                b_tail;

  logic                           node_we_hi;
  logic                           node_we_lo;
  logic [NW-1:0]                  node_addr;
  logic [NODE_HI_W+NODE_LO_W-1:0] node_wdata;
  logic [NODE_HI_W+NODE_LO_W-1:0] node_rdata;
  logic [KEY_W-1:0]               n_key;
  logic [VALUE_W-1:0]             n_val;
  logic                           n_end;
  logic [NW-1:0]                  n_link;

  // effective bucket count: zero acts as one, clamp to table size or 511, whichever is less
  always_comb begin
    if (cfg_r == '0) begin
      eff_bkt = BCNT_W'(1);
    end else if ({1'b0, cfg_r} > BktCap) begin
      eff_bkt = BktCap[BCNT_W-1:0];
    end else begin
      eff_bkt = cfg_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = rst_n;
  assign pool_full = (alloc_r == CW'(NODE_POOL_SIZE));
  assign new_idx   = alloc_r[NW-1:0];
  assign slot_free = !out_valid_r || !out_stall;

  chmap_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_beat),
    .key     (in_data.key),
    .divisor (eff_bkt),
    .stat    (mod_st),
    .rem     (mod_rem)
  );

  // bucket table: {used, head, tail}
  assign b_used = bkt_rdata[2*NW];
  assign b_head = bkt_rdata[2*NW-1:NW];
  assign b_tail = bkt_rdata[NW-1:0];

  always_comb begin
    bkt_we    = (state_r == S_CLEAR) || (state_r == S_BCHK && op_r == OP_ADD);
    bkt_addr  = (state_r == S_CLEAR) ? clr_r : bkt_r;
    bkt_wdata = '0;
    if (state_r != S_CLEAR) begin
      bkt_wdata = {1'b1, (b_used ? b_head : new_idx), new_idx};
    end
  end

  chmap_ram #(
    .DEPTH (MAX_BUCKETS),
    .HI_W  (BKT_HI_W),
    .LO_W  (BKT_LO_W),
    .AW    (BW)
  ) u_bkt_ram (
    .clk   (clk),
    .we_hi (bkt_we),
    .we_lo (bkt_we),
    .addr  (bkt_addr),
    .wdata (bkt_wdata),
    .rdata (bkt_rdata)
  );

  // node pool: {key, value} in the upper lane, {end, link} in the lower lane
  assign n_key  = node_rdata[NODE_LO_W+VALUE_W +: KEY_W];
  assign n_val  = node_rdata[NODE_LO_W +: VALUE_W];
  assign n_end  = node_rdata[NW];
  assign n_link = node_rdata[NW-1:0];

  always_comb begin
    node_we_hi = (state_r == S_BCHK) && (op_r == OP_ADD);
    node_we_lo = node_we_hi || (state_r == S_LINK);
    case (state_r)
      S_BCHK:  node_addr = new_idx;
      S_LINK:  node_addr = tail_r;
      default: node_addr = cur_r;
    endcase
    if (state_r == S_LINK) begin
      node_wdata = {key_r, val_r, 1'b0, nidx_r};
    end else begin
      node_wdata = {key_r, val_r, 1'b1, {NW{1'b0}}};
    end
  end

  chmap_ram #(
    .DEPTH (NODE_POOL_SIZE),
    .HI_W  (NODE_HI_W),
    .LO_W  (NODE_LO_W),
    .AW    (NW)
  ) u_node_ram (
    .clk   (clk),
    .we_hi (node_we_hi),
    .we_lo (node_we_lo),
    .addr  (node_addr),
    .wdata (node_wdata),
    .rdata (node_rdata)
  );

  // sequencer, result and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cfg_r       <= BCNT_W'(256);
      alloc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      // a taken beat drops valid unless the next result loads in its place
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BW'(MAX_BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_beat) begin
            op_r    <= in_data.operation;
            key_r   <= in_data.key;
            val_r   <= in_data.value;
            res_r   <= '0;
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_st.done) begin
            bkt_r <= BW'(mod_rem);
            if (op_r == OP_ADD && pool_full) begin
              res_r.status <= ST_FULL;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_BRD;
            end
          end
        end
        S_BRD: begin
          state_r <= S_BCHK;
        end
        S_BCHK: begin
          if (op_r == OP_ADD) begin
            nidx_r  <= new_idx;
            tail_r  <= b_tail;
            alloc_r <= alloc_r + 1'b1;
            state_r <= b_used ? S_LINK : S_DONE;
          end else if (b_used) begin
            cur_r   <= b_head;
            state_r <= S_NRD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_LINK: begin
          state_r <= S_DONE;
        end
        S_NRD: begin
          state_r <= S_NCHK;
        end
        S_NCHK: begin
          if (n_key == key_r) begin
            res_r.found       <= 1'b1;
            res_r.found_value <= n_val;
            state_r           <= S_DONE;
          end else if (n_end) begin
            state_r <= S_DONE;
          end else begin
            cur_r   <= n_link;
            state_r <= S_NRD;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/chmap_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chmap_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input chmap_pkg::in_beat_t           in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input chmap_pkg::out_beat_t          out_data,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [chmap_pkg::BCNT_W-1:0]  cfg_data
);

  import chmap_pkg::*;

  // a hit never comes with a full status
  `CHK_NEVER(a_hit_not_full, clk, rst_n, out_valid && out_data.found && (out_data.status == ST_FULL), "hit beat carries full status")

  // a miss or an add reports a zero value
  `CHK_IMPLY(a_miss_zero, clk, rst_n, out_valid && !out_data.found, out_data.found_value == '0, "non-hit beat with non-zero value")

  // one item in flight: input stalls right after an accepted beat
  `CHK_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after accepted beat")

  // a stalled result beat holds
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")

endmodule

bind chained_hash_map_insert_lookup_unit chmap_chk u_chmap_chk (.*);
